[rtl/cyc2us_pkg.sv]
// Package: shared types and constants for the cycle-to-microsecond timebase.
`timescale 1ns / 1ps
`default_nettype none

package cyc2us_pkg;

   localparam int unsigned SampleWidth   = 32;
   localparam int unsigned TotalWidth    = 64;
   localparam int unsigned DivisorWidth  = 10;
   localparam int unsigned PrescaleShift = 6;
   localparam int unsigned StepWidth     = 5;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [DivisorWidth-1:0] CyclesPerUsReset = 10'd160;

   localparam logic [CsrIndexWidth-1:0] CsrPrescale    = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrCyclesPerUs = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

[rtl/cycle_to_microsecond_timebase.sv]
// Top level: cycle counter samples in, running microsecond and cycle totals out.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted counter sample yields one result. The delta and the cycle total are formed at
// the accepting edge. Then the item goes through a radix-2 restoring divider (one quotient
// bit per cycle against the 10-bit cycles-per-microsecond divisor), and a fold state folds
// the quotient into the microsecond total and loads the output register.
// The next sample can be taken once the block is back in idle after the fold, so the block
// takes no new sample before it is through with the last. The input is not ready while an
// item is in the divider. The output register lets the next sample be taken while a result
// still waits. A result that has not been taken by the time the next item finishes waits in
// the fold state until it is taken. A divisor of zero adds no microseconds and keeps the whole
// sum as leftover. Configuration writes are always taken.
module cycle_to_microsecond_timebase (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] counter_sample
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,   // [63:0] elapsed_us, [127:64] elapsed_cycles
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [0:0]    csr_index,
   input  wire logic [9:0]    csr_data
);

   localparam int unsigned SW = cyc2us_pkg::SampleWidth;
   localparam int unsigned TW = cyc2us_pkg::TotalWidth;
   localparam int unsigned DW = cyc2us_pkg::DivisorWidth;
   localparam int unsigned PS = cyc2us_pkg::PrescaleShift;
   localparam logic [cyc2us_pkg::StepWidth-1:0] LastStep = 5'd31;

   cyc2us_pkg::state_type state_ff, state_in;

   logic [cyc2us_pkg::StepWidth-1:0] step_ff, step_in;
   logic [SW-1:0]  quo_ff, quo_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  last_sample_ff, last_sample_in;
   logic [SW-1:0]  leftover_ff, leftover_in;
   logic [TW-1:0]  cycle_total_ff, cycle_total_in;
   logic [TW-1:0]  us_total_ff, us_total_in;
   logic           prescale_ff, prescale_in;
   logic [DW-1:0]  cpu_ff, cpu_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2*TW-1:0] rsp_data_ff, rsp_data_in;

   logic [SW-1:0]  raw_delta;
   logic [SW-1:0]  delta;
   logic [SW-1:0]  sum;
   logic [DW:0]    trial;
   logic [DW:0]    trial_diff;
   logic           trial_ge;
   logic           req_fire;
   logic           slot_free;

   assign req_tready = (state_ff == cyc2us_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign raw_delta  = req_tdata - last_sample_ff;
   assign delta      = prescale_ff ? {raw_delta[SW-PS-1:0], {PS{1'b0}}} : raw_delta;
   assign sum        = leftover_ff + delta;

   assign trial      = {rem_ff, quo_ff[SW-1]};
   assign trial_ge   = (trial >= {1'b0, cpu_ff});
   assign trial_diff = trial - {1'b0, cpu_ff};

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      last_sample_in = last_sample_ff;
      leftover_in    = leftover_ff;
      cycle_total_in = cycle_total_ff;
      us_total_in    = us_total_ff;
      prescale_in    = prescale_ff;
      cpu_in         = cpu_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cyc2us_pkg::CsrPrescale:    prescale_in = csr_data[0];
            cyc2us_pkg::CsrCyclesPerUs: cpu_in      = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         cyc2us_pkg::ST_IDLE: begin
            if (req_fire) begin
               last_sample_in = req_tdata;
               cycle_total_in = cycle_total_ff + {{(TW-SW){1'b0}}, delta};
               quo_in         = sum;
               rem_in         = '0;
               step_in        = '0;
               if (cpu_ff == '0) begin
                  leftover_in = sum;
               end
               state_in       = cyc2us_pkg::ST_DIVIDE;
            end
         end
         cyc2us_pkg::ST_DIVIDE: begin
            quo_in  = {quo_ff[SW-2:0], trial_ge};
            rem_in  = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = cyc2us_pkg::ST_FINISH;
            end
         end
         cyc2us_pkg::ST_FINISH: begin
            if (slot_free) begin
               if (cpu_ff != '0) begin
                  us_total_in = us_total_ff + {{(TW-SW){1'b0}}, quo_ff};
                  leftover_in = {{(SW-DW){1'b0}}, rem_ff};
               end
               rsp_data_in  = {cycle_total_ff, us_total_in};
               rsp_valid_in = 1'b1;
               state_in     = cyc2us_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cyc2us_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cyc2us_pkg::ST_IDLE;
         step_ff        <= '0;
         last_sample_ff <= '0;
         leftover_ff    <= '0;
         cycle_total_ff <= '0;
         us_total_ff    <= '0;
         prescale_ff    <= 1'b0;
         cpu_ff         <= cyc2us_pkg::CyclesPerUsReset;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         last_sample_ff <= last_sample_in;
         leftover_ff    <= leftover_in;
         cycle_total_ff <= cycle_total_in;
         us_total_ff    <= us_total_in;
         prescale_ff    <= prescale_in;
         cpu_ff         <= cpu_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input ready while an item is in the divider");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cyc2us_pkg::ST_DIVIDE && step_ff == LastStep)
      |=> state_ff == cyc2us_pkg::ST_FINISH)
      else $error("divider did not finish after its last step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cyc2us_pkg::ST_DIVIDE && cpu_ff != '0) |-> rem_ff < cpu_ff)
      else $error("partial remainder not below divisor");

   a_result_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cyc2us_pkg::ST_FINISH && slot_free) |=> rsp_tvalid)
      else $error("finished item did not present a result");

endmodule

`default_nettype wire
